### design/assert_macros.svh
// Assertion macros shared by the matrix multiply RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/smm_pkg.sv
// Shared constants and types for the square matrix multiply block.
// No dependencies; imported by every module of the block.
package smm_pkg;

   localparam int DEF_MAX_DIM = 64;

   localparam int ELEM_W = 16;
   localparam int PROD_W = 32;
   localparam int SUM_W  = 38;
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 6;
   localparam int SIZE_W = 7;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   localparam logic [FUNC_W-1:0] FUNC_WR_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WR_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ROW  = 2'd2;

   // Per-cycle control from the sequencer to the MAC lanes.
   typedef struct packed {
      logic clear;   // zero all accumulators
      logic mul_en;  // register lane products from the store read data
      logic acc_en;  // add registered products into accumulators
      logic shift;   // move accumulators one lane toward lane 0
   } lane_ctl_type;

endpackage

### design/smm_store.sv
// Element stores: A as one memory addressed by row and column, B as one bank per
// column so a whole row of B is read at once. Depends on smm_pkg.
module smm_store #(
   parameter int MAX_DIM = smm_pkg::DEF_MAX_DIM
) (
   input  logic                                          clock,
   input  logic                                          wr_a,
   input  logic                                          wr_b,
   input  logic [$clog2(MAX_DIM)-1:0]                    wr_row,
   input  logic [$clog2(MAX_DIM)-1:0]                    wr_col,
   input  logic [smm_pkg::ELEM_W-1:0]                    wr_data,
   input  logic                                          rd_en,
   input  logic [$clog2(MAX_DIM)-1:0]                    rd_row,
   input  logic [$clog2(MAX_DIM)-1:0]                    rd_k,
   output logic signed [smm_pkg::ELEM_W-1:0]             a_q,
   output logic [MAX_DIM-1:0][smm_pkg::ELEM_W-1:0]       b_q
);
   import smm_pkg::*;

   localparam int AW    = $clog2(MAX_DIM);
   localparam int DEPTH = MAX_DIM << AW;

   logic [ELEM_W-1:0]               mem_a [DEPTH];
   logic signed [ELEM_W-1:0]        a_q_ff;
   logic [MAX_DIM-1:0][ELEM_W-1:0]  b_q_ff;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[{wr_row, wr_col}] <= wr_data;
      end
      if (rd_en) begin
         a_q_ff <= mem_a[{rd_row, rd_k}];
      end
   end

   for (genvar lane = 0; lane < MAX_DIM; lane++) begin : g_bank
      logic [ELEM_W-1:0] mem_b [MAX_DIM];

      always_ff @(posedge clock) begin
         if (wr_b && (wr_col == AW'(lane))) begin
            mem_b[wr_row] <= wr_data;
         end
         if (rd_en) begin
            b_q_ff[lane] <= mem_b[rd_k];
         end
      end
   end

   assign a_q = a_q_ff;
   assign b_q = b_q_ff;

endmodule

### design/smm_lanes.sv
// MAC lanes, one per result column: registered product, then accumulate.
// After a row the accumulators shift out through lane 0. Depends on smm_pkg.
module smm_lanes #(
   parameter int MAX_DIM = smm_pkg::DEF_MAX_DIM
) (
   input  logic                                     clock,
   input  smm_pkg::lane_ctl_type                    ctl,
   input  logic signed [smm_pkg::ELEM_W-1:0]        a_q,
   input  logic [MAX_DIM-1:0][smm_pkg::ELEM_W-1:0]  b_q,
   output logic signed [smm_pkg::SUM_W-1:0]         head_sum
);
   import smm_pkg::*;

   logic [MAX_DIM-1:0][PROD_W-1:0] prod_ff;
   logic [MAX_DIM-1:0][SUM_W-1:0]  acc_ff;

   for (genvar lane = 0; lane < MAX_DIM; lane++) begin : g_lane
      logic [SUM_W-1:0] shift_src;

      if (lane < MAX_DIM - 1) begin : g_mid
         assign shift_src = acc_ff[lane+1];
      end else begin : g_end
         assign shift_src = '0;
      end

      always_ff @(posedge clock) begin
         if (ctl.mul_en) begin
            prod_ff[lane] <= a_q * $signed(b_q[lane]);
         end
         if (ctl.clear) begin
            acc_ff[lane] <= '0;
         end else if (ctl.acc_en) begin
            // sign-extend the product; the sum wraps at SUM_W bits
            acc_ff[lane] <= acc_ff[lane] + SUM_W'($signed(prod_ff[lane]));
         end else if (ctl.shift) begin
            acc_ff[lane] <= shift_src;
         end
      end
   end

   assign head_sum = $signed(acc_ff[0]);

endmodule

### design/smm_ctrl.sv
// Sequencer: size register, write decode, row read sweep over k, drain of the
// MAC pipeline and emission of one result beat per column. Depends on smm_pkg.
`include "assert_macros.svh"

module smm_ctrl #(
   parameter int MAX_DIM = smm_pkg::DEF_MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [smm_pkg::FUNC_W-1:0]      req_func,
   input  logic [smm_pkg::IDX_W-1:0]       req_row_index,
   input  logic [smm_pkg::IDX_W-1:0]       req_col_index,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [smm_pkg::SIZE_W-1:0]      csr_matrix_size,
   output logic                            wr_a,
   output logic                            wr_b,
   output logic [$clog2(MAX_DIM)-1:0]      wr_row,
   output logic [$clog2(MAX_DIM)-1:0]      wr_col,
   output logic                            rd_en,
   output logic [$clog2(MAX_DIM)-1:0]      rd_row,
   output logic [$clog2(MAX_DIM)-1:0]      rd_k,
   output smm_pkg::lane_ctl_type           lane_ctl,
   output logic                            rsp_strobe,
   output logic [smm_pkg::IDX_W-1:0]       rsp_out_row,
   output logic [smm_pkg::IDX_W-1:0]       rsp_out_col,
   output logic                            rsp_last
);
   import smm_pkg::*;

   localparam int AW = $clog2(MAX_DIM);
   localparam int NW = $clog2(MAX_DIM + 1);
   localparam int IW = (AW > IDX_W) ? AW : IDX_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [NW-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              mul_vld_ff, mul_vld_in;

   logic [NW-1:0]     n_act;
   logic [NW-1:0]     n_last;
   logic [IW-1:0]     row_ext;
   logic [IW-1:0]     col_ext;
   logic              accept;
   logic              in_store;
   logic              row_ok;
   logic              go;

   // sizes above the store saturate to its dimension
   always_comb begin
      if (int'(size_ff) > MAX_DIM) begin
         n_act = NW'(MAX_DIM);
      end else begin
         n_act = NW'(size_ff);
      end
   end

   assign n_last   = n_act - 1'b1;
   assign row_ext  = IW'(req_row_index);
   assign col_ext  = IW'(req_col_index);
   assign accept   = start && !busy;
   assign in_store = (int'(row_ext) < MAX_DIM) && (int'(col_ext) < MAX_DIM);
   assign row_ok   = int'(req_row_index) < int'(n_act);
   assign go       = accept && (req_func == FUNC_ROW) && row_ok;

   assign wr_a   = accept && (req_func == FUNC_WR_A) && in_store;
   assign wr_b   = accept && (req_func == FUNC_WR_B) && in_store;
   assign wr_row = row_ext[AW-1:0];
   assign wr_col = col_ext[AW-1:0];

   // size only changes between rows and never beside a command beat
   assign csr_ready = !busy && !start;
   assign size_in   = (csr_valid && csr_ready) ? csr_matrix_size : size_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_READ;
               k_in     = '0;
               row_in   = req_row_index;
            end
         end
         ST_READ: begin
            k_in = k_ff + 1'b1;
            if (k_ff == n_last) begin
               state_in = ST_DRAIN;
               k_in     = '0;
            end
         end
         ST_DRAIN: begin
            // last product has been accumulated once both stages are empty
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            k_in = k_ff + 1'b1;
            if (k_ff == n_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_vld_in  = (state_ff == ST_READ);
   assign mul_vld_in = rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         size_ff    <= SIZE_RESET;
         k_ff       <= '0;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         size_ff    <= size_in;
         k_ff       <= k_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= mul_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign busy   = (state_ff != ST_IDLE);
   assign rd_en  = (state_ff == ST_READ);
   assign rd_row = AW'(row_ff);
   assign rd_k   = k_ff[AW-1:0];

   assign lane_ctl.clear  = go;
   assign lane_ctl.mul_en = rd_vld_ff;
   assign lane_ctl.acc_en = mul_vld_ff;
   assign lane_ctl.shift  = (state_ff == ST_EMIT);

   assign rsp_strobe  = (state_ff == ST_EMIT);
   assign rsp_out_row = row_ff;
   assign rsp_out_col = IDX_W'(k_ff);
   assign rsp_last    = (k_ff == n_last);

   `SMM_ASSERT_NOW(a_write_only_idle, clock, reset, wr_a || wr_b, state_ff == ST_IDLE, "store write while a row is in flight")
   `SMM_ASSERT_NEXT(a_read_feeds_mul, clock, reset, rd_vld_ff, mul_vld_ff, "read beat lost before the multiply stage")
   `SMM_ASSERT_NEXT(a_last_frees, clock, reset, rsp_strobe && rsp_last, !busy, "block still busy after the last beat")
   `SMM_ASSERT_NOW(a_emit_col_range, clock, reset, rsp_strobe, k_ff < n_act, "emitted column beyond matrix size")

endmodule

### design/square_matrix_multiply.sv
// Top level of the square matrix multiply block; instantiates smm_ctrl,
// smm_store and smm_lanes. Depends on smm_pkg.
//
// Usage:
//  - Commands enter on req_* and are taken at a clock edge with start high and
//    busy low. req_func selects: write an element of A, write an element of B,
//    or compute one row of C = A x B for the row in req_row_index.
//  - A write leaves busy low and the next command may follow.
//  - A row command with a row inside the active size n raises busy. The block
//    reads one A element and one full row of B per cycle over k = 0..n-1, drains
//    a two-stage multiply/accumulate pipeline, then emits the n results of the
//    row in column order, one beat per cycle on rsp_strobe, with rsp_last on the
//    final column. The length of a row command is set by the single read port of
//    the stores (one k per cycle) and the one-beat-per-cycle result port.
//  - Rows at or beyond n, and unused func codes, produce no results.
//  - Result beats last exactly one cycle; the receiver cannot stall them.
//  - csr_* writes matrix_size (reset value 64), taken while the block is idle
//    and start is low.
//  - Reset (synchronous) returns to idle and reloads matrix_size; store contents
//    are undefined until written.
module square_matrix_multiply #(
   parameter int MAX_DIM = smm_pkg::DEF_MAX_DIM
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [smm_pkg::FUNC_W-1:0]            req_func,
   input  logic [smm_pkg::IDX_W-1:0]             req_row_index,
   input  logic [smm_pkg::IDX_W-1:0]             req_col_index,
   input  logic signed [smm_pkg::ELEM_W-1:0]     req_element_value,
   output logic                                  rsp_strobe,
   output logic [smm_pkg::IDX_W-1:0]             rsp_out_row,
   output logic [smm_pkg::IDX_W-1:0]             rsp_out_col,
   output logic signed [smm_pkg::SUM_W-1:0]      rsp_product_value,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [smm_pkg::SIZE_W-1:0]            csr_matrix_size
);
   import smm_pkg::*;

   localparam int AW = $clog2(MAX_DIM);

   logic                           wr_a;
   logic                           wr_b;
   logic [AW-1:0]                  wr_row;
   logic [AW-1:0]                  wr_col;
   logic                           rd_en;
   logic [AW-1:0]                  rd_row;
   logic [AW-1:0]                  rd_k;
   logic signed [ELEM_W-1:0]       a_q;
   logic [MAX_DIM-1:0][ELEM_W-1:0] b_q;
   lane_ctl_type                   lane_ctl;

   smm_ctrl #(
      .MAX_DIM(MAX_DIM)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_matrix_size (csr_matrix_size),
      .wr_a            (wr_a),
      .wr_b            (wr_b),
      .wr_row          (wr_row),
      .wr_col          (wr_col),
      .rd_en           (rd_en),
      .rd_row          (rd_row),
      .rd_k            (rd_k),
      .lane_ctl        (lane_ctl),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last        (rsp_last)
   );

   smm_store #(
      .MAX_DIM(MAX_DIM)
   ) u_store (
      .clock   (clock),
      .wr_a    (wr_a),
      .wr_b    (wr_b),
      .wr_row  (wr_row),
      .wr_col  (wr_col),
      .wr_data (req_element_value),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_k    (rd_k),
      .a_q     (a_q),
      .b_q     (b_q)
   );

   smm_lanes #(
      .MAX_DIM(MAX_DIM)
   ) u_lanes (
      .clock    (clock),
      .ctl      (lane_ctl),
      .a_q      (a_q),
      .b_q      (b_q),
      .head_sum (rsp_product_value)
   );

endmodule

### tb/smm_tb_pkg.sv
// Scoreboard for the square matrix multiply testbench: mirrors the A and B
// stores and the size register, predicts each row of C and checks the beats.
// Depends on smm_pkg.
`timescale 1ns / 1ps
package smm_tb_pkg;
   import smm_pkg::*;

   // func code the block must ignore
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [SUM_W-1:0] value;
      logic                    last;
   } product_beat_type;

   class smm_scoreboard;
      logic signed [ELEM_W-1:0] a_store [DEF_MAX_DIM][DEF_MAX_DIM];
      logic signed [ELEM_W-1:0] b_store [DEF_MAX_DIM][DEF_MAX_DIM];
      logic [SIZE_W-1:0]        size_reg;
      product_beat_type         product_queue [$];
      int                       errors;
      int                       cmds_seen;
      int                       rows_computed;
      int                       beats_checked;

      function new();
         size_reg      = SIZE_RESET;
         errors        = 0;
         cmds_seen     = 0;
         rows_computed = 0;
         beats_checked = 0;
      endfunction

      function void set_size(logic [SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      function int pending();
         return product_queue.size();
      endfunction

      // Accepted command: update the mirrored stores or predict a row of C.
      function void note_cmd(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [ELEM_W-1:0] value);
         cmds_seen++;
         case (func)
            FUNC_WR_A: a_store[row][col] = value;
            FUNC_WR_B: b_store[row][col] = value;
            FUNC_ROW:  predict_product_row(row);
            default:   ;
         endcase
      endfunction

      function void predict_product_row(logic [IDX_W-1:0] row);
         int                      n;
         logic signed [SUM_W-1:0] acc;
         product_beat_type        beat;
         // sizes above the store dimension saturate
         n = (size_reg > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(size_reg);
         if (row >= n) return;
         rows_computed++;
         for (int c = 0; c < n; c++) begin
            acc = '0;
            for (int k = 0; k < n; k++)
               acc = acc + a_store[row][k] * b_store[k][c];
            beat.row   = row;
            beat.col   = c[IDX_W-1:0];
            beat.value = acc;
            beat.last  = (c == n - 1);
            product_queue.push_back(beat);
         end
      endfunction

      function void compare_field(string what, product_beat_type want,
                                  logic signed [63:0] exp_val, logic signed [63:0] act_val);
         if (act_val !== exp_val) begin
            errors++;
            if (errors <= 40)
               $display("%0t ns: C[%0d][%0d] %s mismatch: expected %0d, got %0d",
                        $time, want.row, want.col, what, exp_val, act_val);
         end
      endfunction

      function void check_beat(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic signed [SUM_W-1:0] value, logic last);
         product_beat_type want;
         if (product_queue.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t ns: unexpected beat: expected none, got C[%0d][%0d] = %0d",
                        $time, row, col, value);
            return;
         end
         want = product_queue.pop_front();
         beats_checked++;
         compare_field("row",   want, want.row,   row);
         compare_field("col",   want, want.col,   col);
         compare_field("value", want, want.value, value);
         compare_field("last",  want, want.last,  last);
      endfunction

      function void flush_check();
         if (product_queue.size() != 0) begin
            errors += product_queue.size();
            $display("%0t ns: %0d expected beats never arrived, expected 0 left",
                     $time, product_queue.size());
         end
      endfunction
   endclass

endpackage

### tb/tb_top.sv
// Top of the square matrix multiply testbench: clock, reset, command and
// size-register drivers, monitor and watchdog. Depends on smm_pkg and
// smm_tb_pkg.
`timescale 1ns / 1ps
module tb_top;
   import smm_pkg::*;
   import smm_tb_pkg::*;

   localparam int DRAIN_CYCLES   = 2 * DEF_MAX_DIM + 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SIZE_MAX_CODE  = (1 << SIZE_W) - 1;
   // corner of the stores that is fully written before any row is computed
   localparam int PRELOAD_DIM    = 5;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [FUNC_W-1:0]       req_func = FUNC_WR_A;
   logic [IDX_W-1:0]        req_row_index = '0;
   logic [IDX_W-1:0]        req_col_index = '0;
   logic signed [ELEM_W-1:0] req_element_value = '0;
   logic                    rsp_strobe;
   logic [IDX_W-1:0]        rsp_out_row;
   logic [IDX_W-1:0]        rsp_out_col;
   logic signed [SUM_W-1:0] rsp_product_value;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [SIZE_W-1:0]       csr_matrix_size = SIZE_RESET;

   smm_scoreboard sb = new();
   int            idle_pct = 37;
   int            cur_size = DEF_MAX_DIM;
   int            stall_count = 0;

   always #2 clock = ~clock;

   square_matrix_multiply dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_matrix_size   (csr_matrix_size)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_cmd(req_func, req_row_index, req_col_index, req_element_value);
         if (rsp_strobe)
            sb.check_beat(rsp_out_row, rsp_out_col, rsp_product_value, rsp_last);
         if (csr_valid && csr_ready)
            sb.set_size(csr_matrix_size);
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog, no beat accepted for %0d cycles", $time, stall_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int g;
      g = 0;
      while (g < 12 && $urandom_range(99) < idle_pct) g++;
      return g;
   endfunction

   function automatic int pick_value();
      case ($urandom_range(9))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return -1;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   function automatic int pick_size(int slot);
      case (slot)
         0:       return PRELOAD_DIM;
         1:       return $urandom_range(PRELOAD_DIM - 1, 2);
         2:       return 1;
         3:       return $urandom_range(SIZE_MAX_CODE, DEF_MAX_DIM + 1);
         4:       return $urandom_range(PRELOAD_DIM, 2);
         5:       return 0;
         6:       return $urandom_range(DEF_MAX_DIM - 1, PRELOAD_DIM + 1);
         7:       return PRELOAD_DIM;
         default: return $urandom_range(PRELOAD_DIM, 1);
      endcase
   endfunction

   // start stays high across back-to-back beats; this task lowers it only for a gap
   task automatic send_cmd(input logic [FUNC_W-1:0] func, input int row,
                           input int col, input int value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_func          <= func;
      req_row_index     <= row[IDX_W-1:0];
      req_col_index     <= col[IDX_W-1:0];
      req_element_value <= value[ELEM_W-1:0];
      do @(posedge clock); while (busy);
   endtask

   task automatic send_random_cmd();
      int                pick;
      int                n;
      int                row;
      int                col;
      logic [FUNC_W-1:0] func;
      n = (cur_size > DEF_MAX_DIM) ? DEF_MAX_DIM : cur_size;
      pick = $urandom_range(99);
      if (pick < 38)      func = FUNC_WR_A;
      else if (pick < 70) func = FUNC_WR_B;
      else if (pick < 95) func = FUNC_ROW;
      else                func = FUNC_UNUSED;
      row = $urandom_range(DEF_MAX_DIM - 1);
      col = $urandom_range(DEF_MAX_DIM - 1);
      // mostly stay inside the active square so writes feed later rows
      if (n > 0 && $urandom_range(99) < 85) begin
         row = $urandom_range(n - 1);
         col = $urandom_range(n - 1);
      end
      // past the preloaded corner only rows outside n may be asked for
      if (func == FUNC_ROW && n > PRELOAD_DIM) begin
         if (n < DEF_MAX_DIM) row = $urandom_range(DEF_MAX_DIM - 1, n);
         else                 func = FUNC_WR_A;
      end
      send_cmd(func, row, col, pick_value());
   endtask

   // rows whose index falls outside n leave no trace, so allow a full row time
   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_size(input int size);
      start <= 1'b0;
      wait_drained();
      csr_valid       <= 1'b1;
      csr_matrix_size <= size[SIZE_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_size = size;
   endtask

   // Every element of the preloaded corner gets written, and rows are only
   // computed at sizes inside it, so no row ever reads an unwritten entry.
   // Top row / left col at +max and bottom row / right col at -max.
   task automatic preload_stores();
      int v;
      for (int r = 0; r < PRELOAD_DIM; r++) begin
         for (int c = 0; c < PRELOAD_DIM; c++) begin
            v = (r == 0) ? 32767 : (r == PRELOAD_DIM - 1) ? -32768 : pick_value();
            send_cmd(FUNC_WR_A, r, c, v);
            v = (c == 0) ? 32767 : (c == PRELOAD_DIM - 1) ? -32768 : pick_value();
            send_cmd(FUNC_WR_B, r, c, v);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      preload_stores();

      // reset size of 64 in force
      send_cmd(FUNC_UNUSED, 63, 63, -32768);
      load_size(PRELOAD_DIM);
      send_cmd(FUNC_ROW, 0, 0, 0);
      send_cmd(FUNC_ROW, PRELOAD_DIM - 1, 0, 0);
      send_cmd(FUNC_ROW, PRELOAD_DIM, 0, 0);
      send_cmd(FUNC_ROW, 63, 0, 0);
      // smallest non-zero size; writes outside the square are kept for later
      load_size(1);
      send_cmd(FUNC_ROW, 0, 0, 0);
      send_cmd(FUNC_ROW, 1, 0, 0);
      send_cmd(FUNC_WR_A, 5, 5, 32767);
      send_cmd(FUNC_WR_B, 5, 2, -1);
      send_cmd(FUNC_ROW, 63, 0, 0);
      // size zero: no row produces output
      load_size(0);
      send_cmd(FUNC_ROW, 0, 0, 0);
      send_cmd(FUNC_UNUSED, 0, 0, 0);
      // oversize code saturates to the store dimension
      load_size(SIZE_MAX_CODE);
      send_cmd(FUNC_WR_A, 63, 63, -32768);
      load_size(3);
      send_cmd(FUNC_ROW, 2, 0, 0);
      send_cmd(FUNC_WR_A, 0, 0, 0);
      send_cmd(FUNC_WR_B, 0, 0, 0);
      send_cmd(FUNC_ROW, 0, 0, 0);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 37 : (phase == 1) ? 74 : 0;
         for (int blk = 0; blk < 3; blk++) begin
            load_size(pick_size(phase * 3 + blk));
            repeat (7) send_random_cmd();
         end
      end

      start <= 1'b0;
      wait_drained();
      sb.flush_check();
      $display("Run covered %0d commands, %0d computed rows, %0d product beats checked,",
               sb.cmds_seen, sb.rows_computed, sb.beats_checked);
      $display("sizes from 0 to %0d including saturation, under three idle patterns",
               SIZE_MAX_CODE);
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
